/* rtl/ybgr_pkg.sv */
// Shared types and constants for the YUY2 to BGR converter.
// No dependencies; used by every module under rtl/.
package ybgr_pkg;

  localparam int LumaW  = 8;
  localparam int ChromaW = 9;   // centered chroma, signed
  localparam int ProdW  = 23;   // signed chroma products
  localparam int MagW   = ProdW - 1;
  localparam int OffW   = 9;    // signed channel offset, |offset| <= 237

  localparam logic [7:0]         CHROMA_BIAS = 8'd128;
  localparam logic signed [15:0] COEF_V_TO_R = 16'sd15748;
  localparam logic signed [15:0] COEF_U_TO_G = -16'sd1873;
  localparam logic signed [15:0] COEF_V_TO_G = -16'sd4681;
  localparam logic signed [15:0] COEF_U_TO_B = 16'sd18556;

  // floor(m / 10000) == (m * RECIP_K) >> RECIP_SH, exact for m < 2**22
  localparam int          RECIP_SH = 36;
  localparam int          RECIP_W  = 23;
  localparam logic [22:0] RECIP_K  = 23'd6871948;

  localparam logic [LumaW-1:0] CHANNEL_MAX = 8'd255;

  typedef struct packed {
    logic [LumaW-1:0]        luma_first;
    logic [LumaW-1:0]        luma_second;
    logic signed [ProdW-1:0] prod_r;
    logic signed [ProdW-1:0] prod_g;
    logic signed [ProdW-1:0] prod_b;
    logic                    last;
  } prod_item_t;

  typedef struct packed {
    logic [LumaW-1:0]       luma_first;
    logic [LumaW-1:0]       luma_second;
    logic signed [OffW-1:0] off_r;
    logic signed [OffW-1:0] off_g;
    logic signed [OffW-1:0] off_b;
    logic                   last;
  } off_item_t;

  typedef struct packed {
    logic [LumaW-1:0] blue_first;
    logic [LumaW-1:0] green_first;
    logic [LumaW-1:0] red_first;
    logic [LumaW-1:0] blue_second;
    logic [LumaW-1:0] green_second;
    logic [LumaW-1:0] red_second;
    logic             last;
  } pix_item_t;

  // divide a signed product by 10000, truncating toward zero
  function automatic logic signed [OffW-1:0] div_scale(input logic signed [ProdW-1:0] p);
    logic [MagW-1:0]          mag;
    logic [MagW+RECIP_W-1:0]  full;
    logic [OffW-1:0]          q;
    mag  = p[ProdW-1] ? MagW'(-p) : MagW'(p);
    full = {{RECIP_W{1'b0}}, mag} * {{MagW{1'b0}}, RECIP_K};
    q    = {1'b0, full[RECIP_SH +: OffW-1]};
    return p[ProdW-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [LumaW-1:0] clamp_sum(input logic [LumaW-1:0] y,
                                                 input logic signed [OffW-1:0] off);
    logic signed [LumaW+1:0] sum;
    sum = $signed({2'b00, y}) + {{(LumaW+2-OffW){off[OffW-1]}}, off};
    if (sum[LumaW+1]) begin
      return '0;
    end else if (sum[LumaW]) begin
      return CHANNEL_MAX;
    end
    return sum[LumaW-1:0];
  endfunction

endpackage

/* rtl/ybgr_chroma_mul.sv */
// Stage 1: centers the chroma bytes and forms the three coefficient products.
// Depends on ybgr_pkg.
module ybgr_chroma_mul import ybgr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_vld,
  output logic             up_rdy,
  input  logic [31:0]      up_data,
  input  logic             up_last,
  output logic             dn_vld,
  input  logic             dn_rdy,
  output prod_item_t       dn_item
);

  logic                      vld_r;
  prod_item_t                item_r;
  prod_item_t                item_nxt;
  logic signed [ChromaW-1:0] u_c;
  logic signed [ChromaW-1:0] v_c;
  logic signed [24:0]        pr;
  logic signed [24:0]        pg;
  logic signed [24:0]        pb;

  assign up_rdy = !vld_r || dn_rdy;

  always_comb begin
    u_c = $signed({1'b0, up_data[15:8]}) - $signed({1'b0, CHROMA_BIAS});
    v_c = $signed({1'b0, up_data[31:24]}) - $signed({1'b0, CHROMA_BIAS});
    pr  = COEF_V_TO_R * v_c;
    pg  = COEF_U_TO_G * u_c + COEF_V_TO_G * v_c;
    pb  = COEF_U_TO_B * u_c;
    item_nxt.luma_first  = up_data[7:0];
    item_nxt.luma_second = up_data[23:16];
    item_nxt.prod_r      = pr[ProdW-1:0];
    item_nxt.prod_g      = pg[ProdW-1:0];
    item_nxt.prod_b      = pb[ProdW-1:0];
    item_nxt.last        = up_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      item_r <= item_nxt;
    end
  end

  assign dn_vld  = vld_r;
  assign dn_item = item_r;

endmodule

/* rtl/ybgr_scale_div.sv */
// Stage 2: divides each product by 10000 toward zero via reciprocal multiply.
// Depends on ybgr_pkg.
module ybgr_scale_div import ybgr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_vld,
  output logic       up_rdy,
  input  prod_item_t up_item,
  output logic       dn_vld,
  input  logic       dn_rdy,
  output off_item_t  dn_item
);

  logic      vld_r;
  off_item_t item_r;
  off_item_t item_nxt;

  assign up_rdy = !vld_r || dn_rdy;

  always_comb begin
    item_nxt.luma_first  = up_item.luma_first;
    item_nxt.luma_second = up_item.luma_second;
    item_nxt.off_r       = div_scale(up_item.prod_r);
    item_nxt.off_g       = div_scale(up_item.prod_g);
    item_nxt.off_b       = div_scale(up_item.prod_b);
    item_nxt.last        = up_item.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      item_r <= item_nxt;
    end
  end

  assign dn_vld  = vld_r;
  assign dn_item = item_r;

endmodule

/* rtl/ybgr_mix_clamp.sv */
// Stage 3: adds the offsets to both lumas, clamps to 0..255, holds the output item.
// Depends on ybgr_pkg.
module ybgr_mix_clamp import ybgr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_vld,
  output logic      up_rdy,
  input  off_item_t up_item,
  output logic      dn_vld,
  input  logic      dn_rdy,
  output pix_item_t dn_item
);

  logic      vld_r;
  pix_item_t item_r;
  pix_item_t item_nxt;

  assign up_rdy = !vld_r || dn_rdy;

  always_comb begin
    item_nxt.blue_first   = clamp_sum(up_item.luma_first,  up_item.off_b);
    item_nxt.green_first  = clamp_sum(up_item.luma_first,  up_item.off_g);
    item_nxt.red_first    = clamp_sum(up_item.luma_first,  up_item.off_r);
    item_nxt.blue_second  = clamp_sum(up_item.luma_second, up_item.off_b);
    item_nxt.green_second = clamp_sum(up_item.luma_second, up_item.off_g);
    item_nxt.red_second   = clamp_sum(up_item.luma_second, up_item.off_r);
    item_nxt.last         = up_item.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      item_r <= item_nxt;
    end
  end

  assign dn_vld  = vld_r;
  assign dn_item = item_r;

endmodule

/* rtl/yuy2_to_bgr_converter.sv */
// YUY2 macropixel to two BGR pixels with BT.709-style integer coefficients.
// Three-stage pipeline (multiply, divide, clamp), each stage registered; every stage holds
// its item under back-pressure and fills bubbles, so the rate is one item per cycle
// whenever the output side takes one per cycle.
// Depends on ybgr_pkg, ybgr_chroma_mul, ybgr_scale_div, ybgr_mix_clamp.
module yuy2_to_bgr_converter import ybgr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // luma_first, chroma_blue, luma_second, chroma_red
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // blue_first, green_first, red_first,
                                  // blue_second, green_second, red_second
  output logic        out_tlast   // frame_end_out
);

  logic       s1_vld;
  logic       s1_rdy;
  prod_item_t s1_item;
  logic       s2_vld;
  logic       s2_rdy;
  off_item_t  s2_item;
  pix_item_t  s3_item;

  ybgr_chroma_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (in_tvalid),
    .up_rdy  (in_tready),
    .up_data (in_tdata),
    .up_last (in_tlast),
    .dn_vld  (s1_vld),
    .dn_rdy  (s1_rdy),
    .dn_item (s1_item)
  );

  ybgr_scale_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (s1_vld),
    .up_rdy  (s1_rdy),
    .up_item (s1_item),
    .dn_vld  (s2_vld),
    .dn_rdy  (s2_rdy),
    .dn_item (s2_item)
  );

  ybgr_mix_clamp u_clamp (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (s2_vld),
    .up_rdy  (s2_rdy),
    .up_item (s2_item),
    .dn_vld  (out_tvalid),
    .dn_rdy  (out_tready),
    .dn_item (s3_item)
  );

  assign out_tdata = {s3_item.red_second, s3_item.green_second, s3_item.blue_second,
                      s3_item.red_first,  s3_item.green_first,  s3_item.blue_first};
  assign out_tlast = s3_item.last;

endmodule
